// ===== sv/swrm_pkg.sv =====
package swrm_pkg;

    localparam int unsigned SWR_MAX      = 9990;
    localparam int unsigned SWR_UNITY    = 100;
    localparam int unsigned FWD_SHIFT    = 4;
    localparam int unsigned DIODE_OFFSET = 82;
    localparam int unsigned BRIDGE_DIV   = 84;
    localparam int unsigned POWER_DIV    = 50000;

    // queue depths between the parts
    localparam int unsigned SWRM_CMD_DEPTH = 2;
    localparam int unsigned SWRM_RES_DEPTH = 2;

    // reciprocal multipliers: exact floor division for the operand widths used
    localparam int unsigned VC_W       = 21;
    localparam int unsigned BRIDGE_SH  = VC_W + 7;
    localparam logic [21:0] BRIDGE_M   =
        22'(((64'd1 << BRIDGE_SH) + 64'(BRIDGE_DIV) - 64'd1) / 64'(BRIDGE_DIV));
    localparam int unsigned SQ_W       = 28;
    localparam int unsigned POWER_SH   = SQ_W + 16;
    localparam logic [28:0] POWER_M    =
        29'(((64'd1 << POWER_SH) + 64'(POWER_DIV) - 64'd1) / 64'(POWER_DIV));

    // swr division: quotient is known to stay below 2^QUO_W once clamping is ruled out
    localparam int unsigned QUO_W       = 14;
    localparam int unsigned PREP_CYCLES = 5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FORWARD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_CAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWR_TRIGGER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PTT2_INVERTED = 3'd5;

    typedef struct packed {
        logic [15:0] forward_level;
        logic [15:0] reflected_level;
        logic        keyed;
        logic        over_temperature;
    } t_in_item;

    typedef struct packed {
        logic [13:0] swr_x100;
        logic [15:0] power_mw;
        logic        alarm_active;
        logic        ptt2_level;
    } t_out_item;

    typedef struct packed {
        logic [15:0] min_forward_level;
        logic [7:0]  power_calibration;
        logic [15:0] min_power_mw;
        logic [7:0]  swr_trigger_x10;
        logic [7:0]  protect_ticks;
        logic        ptt2_inverted;
    } t_cfg;

    // classified sample handed from front to back
    typedef struct packed {
        logic [15:0] forward_level;
        logic [15:0] reflected_level;
        logic        measure;
        logic        below_min;
        logic        refl_ge_fwd;
    } t_cmd;

endpackage

// ===== sv/swr_meter_with_alarm.sv =====
// swr and forward power meter with high-swr alarm and secondary ptt line.
// input side: drive i_item and raise push; a transaction completes on a clock
// edge with push high and full low. results: while empty is low the oldest
// result sits on o_result; pop high on a clock edge takes it.
// configuration: i_cfg_we with i_cfg_idx/i_cfg_data writes one register; the
// user must write only while the meter is idle, which the block itself does
// not enforce; unknown indexes are ignored. a front stage classifies each
// sample into a 2-entry command queue; the back stage runs a power chain
// (v, vc, p1, sq, pw; two reciprocal multiplies) and then a 14-step restoring
// divider for 100*(f+r)/(f-r), one quotient bit a cycle. the back stage takes
// no new sample until it has written the last result, passing through pop,
// the power chain, the divider loop and the write state in turn.
// if the receiver stops popping, results collect in a 2-entry result queue,
// then the back stage holds, then the command queue fills and full rises.
// synchronous active-low reset empties both queues, loads the register reset
// values and sets swr 1.00, alarm off, ptt2 at its released level.
module swr_meter_with_alarm import swrm_pkg::*; #(
    parameter int unsigned CMD_DEPTH = SWRM_CMD_DEPTH,
    parameter int unsigned RES_DEPTH = SWRM_RES_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg, n_cfg;
    t_cmd      w_cmd_in, w_cmd_out;
    logic      w_cmd_empty, w_cmd_pop;
    logic      w_res_full, w_res_push;
    t_out_item w_res;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_FORWARD:   n_cfg.min_forward_level = i_cfg_data;
                CFG_POWER_CAL:     n_cfg.power_calibration = i_cfg_data[7:0];
                CFG_MIN_POWER:     n_cfg.min_power_mw      = i_cfg_data;
                CFG_SWR_TRIGGER:   n_cfg.swr_trigger_x10   = i_cfg_data[7:0];
                CFG_PROTECT_TICKS: n_cfg.protect_ticks     = i_cfg_data[7:0];
                CFG_PTT2_INVERTED: n_cfg.ptt2_inverted     = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_forward_level <= 16'd256;
            r_cfg.power_calibration <= 8'd128;
            r_cfg.min_power_mw      <= 16'd500;
            r_cfg.swr_trigger_x10   <= 8'd27;
            r_cfg.protect_ticks     <= 8'd10;
            r_cfg.ptt2_inverted     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    swrm_front u_front (
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_cmd  (w_cmd_in)
    );

    swrm_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    swrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    swrm_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== sv/swrm_fifo.sv =====
module swrm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr_en, w_rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/swrm_front.sv =====
module swrm_front import swrm_pkg::*; (
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_cmd     o_cmd
);

    always_comb begin
        o_cmd.forward_level   = i_item.forward_level;
        o_cmd.reflected_level = i_item.reflected_level;
        o_cmd.measure         = i_item.keyed && !i_item.over_temperature;
        o_cmd.below_min       = i_item.forward_level < i_cfg.min_forward_level;
        o_cmd.refl_ge_fwd     = i_item.reflected_level >= i_item.forward_level;
    end

endmodule

// ===== sv/swrm_back.sv =====
module swrm_back import swrm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_empty,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PREP  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    t_cmd  r_cmd;

    // power chain
    logic [12:0]     r_v;
    logic [VC_W-1:0] r_vc;
    logic [13:0]     r_p1;
    logic [SQ_W-1:0] r_sq;
    logic [15:0]     r_pw;
    logic [42:0]     w_p1_prod;
    logic [56:0]     w_pw_prod;

    // swr division
    logic [23:0]      r_num;
    logic [15:0]      r_den;
    logic [29:0]      r_lim;
    logic             r_clamp, n_clamp;
    logic [15:0]      r_rem, n_rem;
    logic [QUO_W-1:0] r_nlo, n_nlo;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [16:0]      w_trial;

    // meter state
    logic        r_high, n_high;
    logic [7:0]  r_pat, n_pat;
    logic        r_alarm, n_alarm;
    logic [13:0] r_held, n_held;
    logic        r_ptt2, n_ptt2;
    logic [13:0] w_swr;
    logic [13:0] w_trig;
    logic        w_released;

    assign w_p1_prod = 43'(r_vc) * 43'(BRIDGE_M);
    assign w_pw_prod = 57'(r_sq) * 57'(POWER_M);

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        r_v   <= (r_cmd.forward_level != '0)
               ? 13'(r_cmd.forward_level >> FWD_SHIFT) + 13'(DIODE_OFFSET) : '0;
        r_vc  <= VC_W'(r_v) * VC_W'(i_cfg.power_calibration);
        r_p1  <= w_p1_prod[BRIDGE_SH+13:BRIDGE_SH];
        r_sq  <= SQ_W'(r_p1) * SQ_W'(r_p1);
        r_pw  <= 16'(w_pw_prod[56:POWER_SH]);
        r_num <= 24'(17'(r_cmd.forward_level) + 17'(r_cmd.reflected_level))
               * 24'(SWR_UNITY);
        r_den <= r_cmd.forward_level - r_cmd.reflected_level;
        r_lim <= 30'(r_den) * 30'(SWR_MAX);
        r_clamp <= n_clamp;
        r_rem   <= n_rem;
        r_nlo   <= n_nlo;
        r_quo   <= n_quo;
    end

    assign w_trial    = {r_rem, r_nlo[QUO_W-1]};
    assign w_released = ~i_cfg.ptt2_inverted;
    assign w_trig     = 14'(i_cfg.swr_trigger_x10) * 14'd10;

    always_comb begin
        if (!r_cmd.measure) begin
            w_swr = r_held;
        end else if (r_cmd.below_min) begin
            w_swr = 14'(SWR_UNITY);
        end else if (r_cmd.refl_ge_fwd || r_clamp) begin
            w_swr = 14'(SWR_MAX);
        end else begin
            w_swr = r_quo;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_clamp    = r_clamp;
        n_rem      = r_rem;
        n_nlo      = r_nlo;
        n_quo      = r_quo;
        n_high     = r_high;
        n_pat      = r_pat;
        n_alarm    = r_alarm;
        n_held     = r_held;
        n_ptt2     = r_ptt2;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cnt     = '0;
                    n_state   = ST_PREP;
                end
            end
            ST_PREP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'(PREP_CYCLES - 1)) begin
                    n_clamp = 30'(r_num) >= r_lim;
                    n_rem   = 16'(r_num[23:QUO_W]);
                    n_nlo   = r_num[QUO_W-1:0];
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                n_nlo = r_nlo << 1;
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem = 16'(w_trial - {1'b0, r_den});
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[15:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                if (r_cnt == 4'(QUO_W - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_cmd.measure) begin
                        n_held = w_swr;
                        if (r_pw > i_cfg.min_power_mw && w_swr > w_trig) begin
                            if (!r_high) begin
                                n_high = 1'b1;
                            end else begin
                                n_alarm = 1'b1;
                                n_ptt2  = w_released;
                                n_pat   = i_cfg.protect_ticks;
                            end
                        end else if (r_pat == '0) begin
                            n_alarm = 1'b0;
                            n_ptt2  = ~w_released;
                            n_high  = 1'b0;
                        end else begin
                            n_pat = r_pat - 1'b1;
                        end
                    end else begin
                        n_alarm = 1'b0;
                        n_ptt2  = w_released;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.swr_x100     = n_held;
        o_res.power_mw     = r_pw;
        o_res.alarm_active = n_alarm;
        o_res.ptt2_level   = n_ptt2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_high  <= 1'b0;
            r_pat   <= '0;
            r_alarm <= 1'b0;
            r_held  <= 14'(SWR_UNITY);
            r_ptt2  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_pat   <= n_pat;
            r_alarm <= n_alarm;
            r_held  <= n_held;
            r_ptt2  <= n_ptt2;
        end
    end

endmodule
